// ===== rtl/hps_pkg.sv =====
// Shared types, constants and helper functions for the hop packet sequencer.
// Used by the channel interfaces and by every module of the block.
// No dependencies.
package hps_pkg;

  localparam int CAL_CHANNELS = 50;
  localparam int CAL_IDX_W    = $clog2(CAL_CHANNELS);

  localparam int CHAN_W  = 6;
  localparam int SLOT_W  = 12;
  localparam int BYTE_W  = 8;
  localparam int ID_W    = 16;
  localparam int CODE_W  = 5;
  localparam int FC_W    = 10;
  localparam int WAIT_W  = 13;
  localparam int ADDR_W  = 6;
  localparam int CMD_W   = 4;
  localparam int GROUP_N = 4;

  localparam int FRAME_BYTES = 13;
  localparam int STEP_W      = $clog2(FRAME_BYTES + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int CFG_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic CFG_IDX_TX_ID = 1'b0;
  localparam logic CFG_IDX_HOP   = 1'b1;

  localparam logic [ADDR_W-1:0] STROBE_IDLE = 6'h36;
  localparam logic [ADDR_W-1:0] STROBE_CAL  = 6'h33;
  localparam logic [ADDR_W-1:0] REG_CHAN    = 6'h0A;
  localparam logic [ADDR_W-1:0] REG_FINECAL = 6'h25;

  localparam logic [BYTE_W-1:0] CHAN_BASE    = 8'd16;
  localparam logic [BYTE_W-1:0] CHAN_SPACING = 8'd6;
  localparam logic [BYTE_W-1:0] FRAME_SYNC   = 8'h81;

  localparam logic [WAIT_W-1:0] WAIT_CAL  = 13'd2000;
  localparam logic [WAIT_W-1:0] WAIT_DATA = 13'd2020;
  localparam logic [WAIT_W-1:0] PERIOD_US = 13'd6798;
  localparam logic [WAIT_W-1:0] WAIT_TUNE = PERIOD_US - WAIT_DATA - WAIT_DATA;

  localparam logic [CMD_W-1:0] CMD_BASE = 4'h2;
  localparam logic [CMD_W-1:0] CMD_PKT  = 4'h1;
  localparam logic [CMD_W-1:0] CMD_ODD  = 4'h8;

  localparam logic [BYTE_W-1:0] HOP_LIMIT = 8'd29;
  localparam logic [BYTE_W-1:0] HOP_SKIP  = 8'd30;
  localparam logic [BYTE_W-1:0] HOP_MOD   = 8'd31;

  typedef enum logic [1:0] {
    KIND_STROBE = 2'd0,
    KIND_REG    = 2'd1,
    KIND_BYTE   = 2'd2,
    KIND_WAIT   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    JOB_TUNE_CAL,
    JOB_WAIT_CAL,
    JOB_FRAME,
    JOB_TUNE_FINE
  } job_kind_t;

  typedef struct packed {
    logic [ID_W-1:0]   tx_id;
    logic [CODE_W-1:0] hop_code;
  } cfg_t;

  typedef struct packed {
    job_kind_t                      kind;
    logic [CHAN_W-1:0]              chan;
    logic [BYTE_W-1:0]              cal;
    logic [CMD_W-1:0]               cmd;
    logic [GROUP_N-1:0][SLOT_W-1:0] ch;
    cfg_t                           cfg;
  } job_t;

  function automatic logic [BYTE_W-1:0] chan_reg(input logic [CHAN_W-1:0] chan);
    logic [BYTE_W:0] prod;
    prod = {{(BYTE_W + 1 - CHAN_W){1'b0}}, chan} * {1'b0, CHAN_SPACING};
    return prod[BYTE_W-1:0] + CHAN_BASE;
  endfunction

endpackage

// ===== rtl/hps_if.sv =====
// Valid/ready channel interfaces for the input ticks and the result items.
// Depends on hps_pkg for field widths.
interface hps_in_if import hps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot0;
  logic [SLOT_W-1:0] slot1;
  logic [SLOT_W-1:0] slot2;
  logic [SLOT_W-1:0] slot3;
  logic [SLOT_W-1:0] slot4;
  logic [SLOT_W-1:0] slot5;
  logic [SLOT_W-1:0] slot6;
  logic [SLOT_W-1:0] slot7;
  logic [BYTE_W-1:0] cal_readback;

  modport source (output valid, slot0, slot1, slot2, slot3, slot4, slot5, slot6, slot7,
                  cal_readback, input ready);
  modport sink   (input valid, slot0, slot1, slot2, slot3, slot4, slot5, slot6, slot7,
                  cal_readback, output ready);
endinterface

interface hps_out_if import hps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [ADDR_W-1:0] reg_addr;
  logic [BYTE_W-1:0] data_byte;
  logic [WAIT_W-1:0] wait_us;
  logic              last;

  modport source (output valid, kind, reg_addr, data_byte, wait_us, last, input ready);
  modport sink   (input valid, kind, reg_addr, data_byte, wait_us, last, output ready);
endinterface

// ===== rtl/hps_front.sv =====
// Front end: accepts ticks, runs the phase machine, keeps the calibration memory
// and turns each tick into one job for the back end. Depends on hps_pkg, hps_if.
module hps_front import hps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  hps_in_if.sink     in_ch,
  input  cfg_t       cfg,
  input  logic       q_ready,
  output logic       push,
  output job_t       push_job
);

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_CAL   = 3'd1,
    PH_DATA1 = 3'd2,
    PH_DATA2 = 3'd3,
    PH_TUNE  = 3'd4
  } phase_t;

  localparam logic [CHAN_W:0] CAL_LIMIT = (CHAN_W + 1)'(CAL_CHANNELS);

  phase_t            phase_r, phase_nxt;
  logic [CHAN_W-1:0] chan_r, chan_nxt, chan_upd;
  logic [FC_W-1:0]   fc_r, fc_nxt, fc_upd, fc_inc;
  logic              cal_ok_r, cal_ok_nxt;
  logic [BYTE_W-1:0] cal_rd_r;
  logic [BYTE_W-1:0] cal_mem [CAL_CHANNELS];
  logic [CAL_IDX_W-1:0] cal_rd_addr, cal_wr_addr;
  logic              cal_wr, cal_wr_upd;
  logic [CHAN_W:0]   cal_next;
  phase_t            phase_upd;

  logic [BYTE_W-1:0] hop_step, hop_sum, hop_adj, hop_val;
  logic [GROUP_N-1:0][SLOT_W-1:0] grp_lo, grp_hi;
  logic              accept;

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && q_ready;
  assign push        = accept;

  assign grp_lo = {in_ch.slot3, in_ch.slot2, in_ch.slot1, in_ch.slot0};
  assign grp_hi = {in_ch.slot7, in_ch.slot6, in_ch.slot5, in_ch.slot4};

  assign fc_inc   = fc_r + 1'b1;
  assign cal_next = {1'b0, chan_r} + 1'b1;

  assign hop_step = BYTE_W'(cfg.hop_code) + 8'd2;
  assign hop_sum  = BYTE_W'(chan_r) + hop_step;
  assign hop_adj  = (hop_sum == HOP_SKIP) ? hop_sum + hop_step : hop_sum;
  assign hop_val  = (hop_sum > HOP_LIMIT) ? hop_adj - HOP_MOD : hop_sum;

  always_comb begin
    phase_upd  = phase_r;
    chan_upd   = chan_r;
    fc_upd     = fc_r;
    cal_wr_upd = 1'b0;
    push_job.kind = JOB_WAIT_CAL;
    push_job.chan = chan_r;
    push_job.cal  = cal_ok_r ? cal_rd_r : '0;
    push_job.cmd  = CMD_BASE;
    push_job.ch   = grp_lo;
    push_job.cfg  = cfg;
    case (phase_r)
      PH_CAL: begin
        cal_wr_upd = ({1'b0, chan_r} < CAL_LIMIT);
        if (cal_next < CAL_LIMIT) begin
          chan_upd      = cal_next[CHAN_W-1:0];
          push_job.kind = JOB_TUNE_CAL;
          push_job.chan = cal_next[CHAN_W-1:0];
        end else begin
          chan_upd  = '0;
          fc_upd    = '0;
          phase_upd = PH_DATA1;
        end
      end
      PH_DATA1: begin
        push_job.kind = JOB_FRAME;
        push_job.cmd  = CMD_BASE | (fc_r[0] ? CMD_ODD : '0);
        push_job.ch   = fc_r[0] ? grp_hi : grp_lo;
        phase_upd     = PH_DATA2;
      end
      PH_DATA2: begin
        fc_upd        = fc_inc;
        push_job.kind = JOB_FRAME;
        push_job.cmd  = CMD_BASE | CMD_PKT | (fc_inc[0] ? CMD_ODD : '0);
        push_job.ch   = fc_inc[0] ? grp_hi : grp_lo;
        chan_upd      = hop_val[CHAN_W-1:0];
        phase_upd     = PH_TUNE;
      end
      PH_TUNE: begin
        push_job.kind = JOB_TUNE_FINE;
        phase_upd     = PH_DATA1;
      end
      default: begin
        chan_upd      = '0;
        push_job.kind = JOB_TUNE_CAL;
        push_job.chan = '0;
        phase_upd     = PH_CAL;
      end
    endcase
  end

  always_comb begin
    phase_nxt  = accept ? phase_upd : phase_r;
    chan_nxt   = accept ? chan_upd : chan_r;
    fc_nxt     = accept ? fc_upd : fc_r;
    cal_wr     = accept && cal_wr_upd;
    cal_ok_nxt = ({1'b0, chan_nxt} < CAL_LIMIT);
    cal_rd_addr = cal_ok_nxt ? chan_nxt[CAL_IDX_W-1:0] : '0;
    cal_wr_addr = chan_r[CAL_IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      chan_r   <= '0;
      fc_r     <= '0;
      cal_ok_r <= 1'b1;
    end else begin
      phase_r  <= phase_nxt;
      chan_r   <= chan_nxt;
      fc_r     <= fc_nxt;
      cal_ok_r <= cal_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cal_wr) begin
      cal_mem[cal_wr_addr] <= in_ch.cal_readback;
    end
    cal_rd_r <= cal_mem[cal_rd_addr];
  end

endmodule

// ===== rtl/hps_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on hps_pkg for the job type and depth.
module hps_queue import hps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic push_ready,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign push_ready = (count_r != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = q_mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/hps_back.sv =====
// Back end: expands the job at the queue head into result items, one per cycle,
// unless stalled, through a single output register. Depends on hps_pkg, hps_if.
module hps_back import hps_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   head_valid,
  input  job_t   head_job,
  output logic   pop,
  hps_out_if.source out_ch
);

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] reg_addr;
    logic [BYTE_W-1:0] data_byte;
    logic [WAIT_W-1:0] wait_us;
    logic              last;
  } res_t;

  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  res_t              out_r;
  res_t              res;
  logic [BYTE_W-1:0] fbyte;
  logic [BYTE_W-1:0] creg;
  logic              adv;

  assign creg = chan_reg(head_job.chan);

  always_comb begin
    case (step_r)
      4'd0:    fbyte = FRAME_SYNC;
      4'd1:    fbyte = head_job.cfg.tx_id[15:8];
      4'd2:    fbyte = head_job.cfg.tx_id[7:0];
      4'd3:    fbyte = '0;
      4'd4:    fbyte = '0;
      4'd5:    fbyte = {head_job.chan[4:0], head_job.ch[0][11:9]};
      4'd6:    fbyte = head_job.ch[0][8:1];
      4'd7:    fbyte = {head_job.ch[0][0], head_job.ch[1][11:5]};
      4'd8:    fbyte = {head_job.ch[1][4:0], head_job.ch[2][11:9]};
      4'd9:    fbyte = head_job.ch[2][8:1];
      4'd10:   fbyte = {head_job.ch[2][0], head_job.ch[3][11:5]};
      4'd11:   fbyte = {head_job.ch[3][4:0], head_job.cfg.hop_code[4:2]};
      4'd12:   fbyte = {head_job.cfg.hop_code[1:0], 2'b00, head_job.cmd};
      default: fbyte = '0;
    endcase
  end

  always_comb begin
    res = '{kind: KIND_WAIT, reg_addr: '0, data_byte: '0, wait_us: '0, last: 1'b0};
    case (head_job.kind)
      JOB_TUNE_CAL, JOB_TUNE_FINE: begin
        case (step_r)
          4'd0: begin
            res.kind     = KIND_STROBE;
            res.reg_addr = STROBE_IDLE;
          end
          4'd1: begin
            res.kind      = KIND_REG;
            res.reg_addr  = REG_CHAN;
            res.data_byte = creg;
          end
          4'd2: begin
            if (head_job.kind == JOB_TUNE_FINE) begin
              res.kind      = KIND_REG;
              res.reg_addr  = REG_FINECAL;
              res.data_byte = head_job.cal;
            end else begin
              res.kind     = KIND_STROBE;
              res.reg_addr = STROBE_CAL;
            end
          end
          default: begin
            res.kind    = KIND_WAIT;
            res.wait_us = (head_job.kind == JOB_TUNE_FINE) ? WAIT_TUNE : WAIT_CAL;
          end
        endcase
      end
      JOB_FRAME: begin
        if (step_r < STEP_W'(FRAME_BYTES)) begin
          res.kind      = KIND_BYTE;
          res.data_byte = fbyte;
        end else begin
          res.kind    = KIND_WAIT;
          res.wait_us = WAIT_DATA;
        end
      end
      default: begin
        res.kind    = KIND_WAIT;
        res.wait_us = WAIT_CAL;
      end
    endcase
    res.last = (res.kind == KIND_WAIT);
  end

  assign adv = !out_valid_r || out_ch.ready;
  assign pop = adv && head_valid && res.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else if (adv) begin
      out_valid_r <= head_valid;
      if (head_valid) begin
        step_r <= res.last ? '0 : step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && head_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = out_r.kind;
  assign out_ch.reg_addr  = out_r.reg_addr;
  assign out_ch.data_byte = out_r.data_byte;
  assign out_ch.wait_us   = out_r.wait_us;
  assign out_ch.last      = out_r.last;

endmodule

// ===== rtl/hop_packet_sequencer_unit.sv =====
// Hop packet sequencer: one input item per scheduler tick turns into 1, 4 or 14 result
// items (radio strobes, register writes, frame bytes), always closed by a wait item with
// last set. One result item leaves per cycle unless out_ch.ready stalls; a frame tick gives
// 14, a calibration or tune tick 4 and the final calibration tick 1; that output
// register sets the rate. Ticks are accepted every cycle while the two-entry job queue has
// room, also while a result waits at the output. The calibration memory needs no clearing
// after reset. Depends on hps_pkg, hps_if, hps_front, hps_queue and hps_back.
module hop_packet_sequencer_unit import hps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  hps_in_if.sink                in_ch,
  hps_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [ID_W-1:0]   tx_id_r;
  logic [CODE_W-1:0] hop_code_r;
  logic              cfg_wr;
  logic              cfg_sel;
  cfg_t              cfg;

  logic q_push, q_ready, q_pop, q_valid;
  job_t q_push_job, q_head_job;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[CFG_ADDR_W-1];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (cfg_sel == CFG_IDX_HOP) ? APB_DATA_W'(hop_code_r) : APB_DATA_W'(tx_id_r);
  assign cfg     = '{tx_id: tx_id_r, hop_code: hop_code_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_id_r    <= '0;
      hop_code_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_sel == CFG_IDX_TX_ID) begin
        tx_id_r <= pwdata[ID_W-1:0];
      end else begin
        hop_code_r <= pwdata[CODE_W-1:0];
      end
    end
  end

  hps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .q_ready  (q_ready),
    .push     (q_push),
    .push_job (q_push_job)
  );

  hps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_head_job)
  );

  hps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_job   (q_head_job),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

  a_last_is_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.last == (out_ch.kind == KIND_WAIT)))
    else $error("last flag and wait kind disagree");

  a_chan_reg_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == KIND_REG && out_ch.reg_addr == REG_CHAN
    |-> !out_ch.data_byte[0])
    else $error("channel register value is odd");

  a_stall_means_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> q_valid)
    else $error("input stalled with empty job queue");

  a_pop_shows_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_ch.valid && out_ch.last)
    else $error("job retired without a closing item");

endmodule
